@@ design/ebml_pkg.sv @@
// shared types, constants and helper functions for the ebml header router
package ebml_pkg;

	localparam int ID_BYTES_MAX = 4;

	localparam logic [31:0] SEGMENT_ID = 32'h1853_8067;
	localparam logic [31:0] CLUSTER_ID = 32'h1F43_B675;
	localparam logic [55:0] SHORT_ENDLESS_1 = 56'h7F;
	localparam logic [55:0] SHORT_ENDLESS_2 = 56'h3FFF;
	localparam logic [23:0] MAX_LEN_RESET = 24'd262144;

	typedef enum logic [1:0] {
		ROUTE_HEADER  = 2'd0,
		ROUTE_TRACKS  = 2'd1,
		ROUTE_CLUSTER = 2'd2,
		ROUTE_IGNORED = 2'd3
	} route_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_FORMAT   = 2'd1,
		ERR_ENDLESS  = 2'd2,
		ERR_TOO_LONG = 2'd3
	} err_t;

	typedef struct packed {
		logic [31:0] element_id;
		logic [55:0] payload_length;
		logic [3:0]  header_length;
		logic        endless;
		logic        long_coded_endless;
		route_t      route_class;
		err_t        error_code;
	} result_t;

	// number of zero bits above the first one, 8 for a zero byte
	function automatic logic [3:0] lead_zeros(input logic [7:0] b);
		logic [3:0] n;
		logic       found;
		n = 4'd8;
		found = 1'b0;
		for (int i = 7; i >= 0; i--) begin
			if (!found && b[i]) begin
				n = 4'(7 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

	// value is 2^(7k)-1 for some k in 1..8
	function automatic logic value_endless(input logic [55:0] v);
		logic hit;
		hit = 1'b0;
		for (int k = 1; k <= 8; k++) begin
			if (v == ({56{1'b1}} >> (56 - 7 * k)))
				hit = 1'b1;
		end
		return hit;
	endfunction

endpackage

@@ design/ebml_front.sv @@
// byte parser: decodes element headers, classifies them and tracks payload skipping
module ebml_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	input  logic [7:0]           byte_value,
	input  logic                 cfg_we,
	input  logic [23:0]          cfg_data,
	output logic                 res_valid,
	output ebml_pkg::result_t    res
);
	import ebml_pkg::*;

	typedef enum logic [1:0] {
		PH_ID   = 2'd0,
		PH_SIZE = 2'd1,
		PH_SKIP = 2'd2
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [3:0]  left_q, left_d;
	logic [31:0] id_q, id_d;
	logic [55:0] size_q, size_d;
	logic        size_started_q, size_started_d;
	logic [3:0]  hcount_q, hcount_d;
	logic [23:0] pleft_q, pleft_d;
	logic        seg_q, seg_d;
	logic        clu_q, clu_d;
	logic        err_q, err_d;
	logic [23:0] max_len_q;

	logic [3:0]  lz;
	logic [55:0] size_new;
	logic        len_endless;
	logic        len_long;
	logic        len_over;

	assign lz = lead_zeros(byte_value);
	assign size_new = size_started_q ? {size_q[47:0], byte_value}
		: {48'd0, byte_value & (8'h7F >> lz)};
	assign len_endless = value_endless(size_new);
	assign len_long = len_endless && (size_new != SHORT_ENDLESS_1)
		&& (size_new != SHORT_ENDLESS_2);
	assign len_over = (size_new[55:24] != 32'd0) || (size_new[23:0] > max_len_q);

	always_comb begin
		phase_d = phase_q;
		left_d = left_q;
		id_d = id_q;
		size_d = size_q;
		size_started_d = size_started_q;
		hcount_d = hcount_q;
		pleft_d = pleft_q;
		seg_d = seg_q;
		clu_d = clu_q;
		err_d = err_q;
		res_valid = 1'b0;
		res = '0;
		res.route_class = ROUTE_IGNORED;
		res.error_code = ERR_FORMAT;
		if (byte_valid && !err_q) begin
			case (phase_q)
				PH_SKIP: begin
					pleft_d = pleft_q - 24'd1;
					if (pleft_q == 24'd1)
						phase_d = PH_ID;
				end
				PH_SIZE: begin
					if (!size_started_q && byte_value == 8'd0) begin
						res_valid = 1'b1;
						err_d = 1'b1;
					end else begin
						size_d = size_new;
						size_started_d = 1'b1;
						left_d = size_started_q ? left_q - 4'd1 : lz;
						hcount_d = hcount_q + 4'd1;
						if (left_d == 4'd0) begin
							res_valid = 1'b1;
							res.element_id = id_q;
							res.payload_length = size_new;
							res.header_length = hcount_d;
							res.endless = len_endless;
							res.long_coded_endless = len_long;
							res.route_class = ROUTE_IGNORED;
							res.error_code = ERR_NONE;
							if (id_q == SEGMENT_ID) begin
								seg_d = 1'b1;
								clu_d = 1'b0;
								res.route_class = ROUTE_TRACKS;
								phase_d = PH_ID;
							end else if (len_endless || len_over) begin
								res.error_code = len_endless ? ERR_ENDLESS : ERR_TOO_LONG;
								err_d = 1'b1;
							end else begin
								if (!seg_q) begin
									res.route_class = ROUTE_HEADER;
								end else if (id_q == CLUSTER_ID) begin
									clu_d = 1'b1;
									res.route_class = ROUTE_CLUSTER;
								end else if (!clu_q) begin
									res.route_class = ROUTE_TRACKS;
								end
								pleft_d = size_new[23:0];
								phase_d = (size_new[23:0] != 24'd0) ? PH_SKIP : PH_ID;
							end
							left_d = 4'd0;
							id_d = 32'd0;
							size_d = 56'd0;
							size_started_d = 1'b0;
							hcount_d = 4'd0;
						end
					end
				end
				default: begin
					if (hcount_q == 4'd0 && (byte_value == 8'd0
						|| lz >= 4'(ID_BYTES_MAX))) begin
						res_valid = 1'b1;
						err_d = 1'b1;
					end else begin
						if (hcount_q == 4'd0) begin
							id_d = {24'd0, byte_value};
							left_d = lz;
						end else begin
							id_d = {id_q[23:0], byte_value};
							left_d = left_q - 4'd1;
						end
						hcount_d = hcount_q + 4'd1;
						if (left_d == 4'd0) begin
							phase_d = PH_SIZE;
							size_started_d = 1'b0;
						end else begin
							phase_d = PH_ID;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ID;
			left_q <= '0;
			id_q <= '0;
			size_q <= '0;
			size_started_q <= 1'b0;
			hcount_q <= '0;
			pleft_q <= '0;
			seg_q <= 1'b0;
			clu_q <= 1'b0;
			err_q <= 1'b0;
			max_len_q <= MAX_LEN_RESET;
		end else begin
			phase_q <= phase_d;
			left_q <= left_d;
			id_q <= id_d;
			size_q <= size_d;
			size_started_q <= size_started_d;
			hcount_q <= hcount_d;
			pleft_q <= pleft_d;
			seg_q <= seg_d;
			clu_q <= clu_d;
			err_q <= err_d;
			if (cfg_we)
				max_len_q <= cfg_data;
		end
	end

	// once an error is out, the parser stays silent
	a_sticky_silent: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |-> !res_valid)
		else $error("result after sticky error");

	a_result_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> byte_valid)
		else $error("result without an accepted byte");

	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SKIP) |-> (pleft_q != 24'd0))
		else $error("skip phase with nothing left to skip");

endmodule

@@ design/ebml_queue.sv @@
// short queue of decoded headers between the parser and the output stage
module ebml_queue #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ebml_pkg::result_t    push_data,
	input  logic                 deq,
	output ebml_pkg::result_t    head,
	output logic                 q_full,
	output logic                 q_empty
);
	import ebml_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	result_t         mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_deq;

	assign q_full = (count_q == CW'(DEPTH));
	assign q_empty = (count_q == '0);
	assign do_push = push && !q_full;
	assign do_deq = deq && !q_empty;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_deq)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (do_push && !do_deq)
				count_q <= count_q + CW'(1);
			else if (do_deq && !do_push)
				count_q <= count_q - CW'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("push into full queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count out of range");

endmodule

@@ design/ebml_back.sv @@
// output stage: holds the oldest result on the ports until it is popped
module ebml_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  ebml_pkg::result_t    head,
	output logic                 deq,
	input  logic                 pop,
	output logic                 empty,
	output ebml_pkg::result_t    out
);
	import ebml_pkg::*;

	logic    out_valid_q;
	result_t out_q;

	assign deq = !q_empty && (!out_valid_q || pop);
	assign empty = !out_valid_q;
	assign out = out_q;

	always_ff @(posedge clk) begin
		if (deq)
			out_q <= head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (deq) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		deq |=> out_valid_q)
		else $error("loaded result not shown");

endmodule

@@ design/ebml_element_header_router.sv @@
// top level of the ebml element header router
// Takes one stream byte per clock (push while full is low) and, on the last byte of
// each element header outside a skipped payload, queues one item: ID with marker,
// size without marker, header length, endless flags, route class and error code. The
// parser handles a byte every cycle while full is low; an item reaches the result
// ports through a QUEUE_DEPTH-entry queue and an output register, so full only rises
// when results are not popped. After an error item no further items appear until reset.
// The payload length limit is written on the cfg channel, which is always ready.
module ebml_element_header_router #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  byte_value,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] element_id,
	output logic [55:0] payload_length,
	output logic [3:0]  header_length,
	output logic        endless,
	output logic        long_coded_endless,
	output logic [1:0]  route_class,
	output logic [1:0]  error_code,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [23:0] cfg_max_payload_length
);
	import ebml_pkg::*;

	logic    byte_acc;
	logic    res_valid;
	result_t res;
	result_t head;
	result_t out;
	logic    q_empty;
	logic    deq;

	assign cfg_ready = 1'b1;
	assign byte_acc = push && !full;

	ebml_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_acc),
		.byte_value (byte_value),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_max_payload_length),
		.res_valid  (res_valid),
		.res        (res)
	);

	ebml_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.deq       (deq),
		.head      (head),
		.q_full    (full),
		.q_empty   (q_empty)
	);

	ebml_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.head    (head),
		.deq     (deq),
		.pop     (pop),
		.empty   (empty),
		.out     (out)
	);

	assign element_id = out.element_id;
	assign payload_length = out.payload_length;
	assign header_length = out.header_length;
	assign endless = out.endless;
	assign long_coded_endless = out.long_coded_endless;
	assign route_class = out.route_class;
	assign error_code = out.error_code;

endmodule
